### rtl/core/md5bc_pkg.sv
// MD5 block compression: shared types, constants and index functions.
// No dependencies; used by md5bc_round and md5_block_compression_top.
package md5bc_pkg;

  localparam int WordW = 32;

  // Working registers of one compression pass
  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } md5bc_work_t;

  // Standard chaining values
  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hEFCDAB89;
  localparam logic [WordW-1:0] InitC = 32'h98BADCFE;
  localparam logic [WordW-1:0] InitD = 32'h10325476;

  // Per-round additive constants
  localparam logic [WordW-1:0] RoundK [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // Left-rotate amounts, indexed by {phase, round[1:0]}
  localparam logic [4:0] RotAmt [16] = '{
    5'd7,  5'd12, 5'd17, 5'd22,
    5'd5,  5'd9,  5'd14, 5'd20,
    5'd4,  5'd11, 5'd16, 5'd23,
    5'd6,  5'd10, 5'd15, 5'd21
  };

  // Message word used in a given round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = r;
      2'd1:    g = 4'((r << 2) + r + 4'd1);
      2'd2:    g = 4'((r << 1) + r + 4'd5);
      default: g = 4'((r << 3) - r);
    endcase
    return g;
  endfunction

endpackage

### rtl/core/md5bc_round.sv
// One MD5 round: logic function, three-way add, rotate and add into b.
// Depends on md5bc_pkg for the work struct and rotate table.
module md5bc_round (
  input  logic [5:0]               rnd,      // round number 0..63
  input  logic [31:0]              km,       // round constant plus message word
  input  md5bc_pkg::md5bc_work_t   cur,
  output md5bc_pkg::md5bc_work_t   nxt
);
  import md5bc_pkg::*;

  logic [1:0]       phase;
  logic [WordW-1:0] f;
  logic [WordW-1:0] sum;
  logic [4:0]       sh;
  logic [2*WordW-1:0] dbl;
  logic [WordW-1:0] rot;

  assign phase = rnd[5:4];

  // Select the round function for this phase
  always_comb begin
    case (phase)
      2'd0:    f = cur.d ^ (cur.b & (cur.c ^ cur.d));
      2'd1:    f = cur.c ^ (cur.d & (cur.b ^ cur.c));
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
  end

  // Add, then rotate left through a doubled word
  assign sum = cur.a + f + km;
  assign sh  = RotAmt[{phase, rnd[1:0]}];
  assign dbl = {sum, sum} << sh;
  assign rot = dbl[2*WordW-1:WordW];

  // Shift the working words along
  assign nxt.a = cur.d;
  assign nxt.b = cur.b + rot;
  assign nxt.c = cur.b;
  assign nxt.d = cur.c;

endmodule

### rtl/core/md5_block_compression_top.sv
// MD5 block compression top: word store, chaining words, round sequencer
// and digest output. Depends on md5bc_pkg and md5bc_round.
//
//  channel | dir | tdata          | tuser                          | tlast
//  in_     | in  | msg_word[31:0] | [0] start_message [1] final_block | -
//  out_    | out | digest_word    | [1:0] digest_index             | last_word
//
// Words are taken one a cycle while in_tready is high. The sixteenth
// word of a block starts a pass (a load, 64 rounds through the single
// round unit, a chaining add), during which in_tready is low. After a
// final block four digest items follow, one a cycle while out_tready is
// high; a low out_tready holds the current item. Reset (synchronous,
// rst_n low) loads the standard chaining values and clears the word count.
module md5_block_compression_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] msg_word
  input  logic [1:0]  in_tuser,   // [0] start_message, [1] final_block
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] digest_index
  output logic        out_tlast
);
  import md5bc_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [3:0]       wcnt_r, wcnt_nxt;
  logic [5:0]       rnd_r, rnd_nxt;
  logic [1:0]       oidx_r, oidx_nxt;
  logic             final_r, final_nxt;
  logic [WordW-1:0] chain_r [4];
  logic [WordW-1:0] chain_nxt [4];
  md5bc_work_t      work_r, work_nxt, round_out;
  logic [WordW-1:0] km_r;
  logic [WordW-1:0] store [16];
  logic [5:0]       rnd_ahead;
  logic [5:0]       rnd_sel;
  logic             in_acc;
  logic             out_acc;
  logic [3:0]       wr_idx;

  assign in_tready  = (state_r == StIdle);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == StEmit);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = chain_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 2'd3);

  // A start flag restarts the block at word zero
  assign wr_idx = in_tuser[0] ? 4'd0 : wcnt_r;

  // Write the message word store
  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[wr_idx] <= in_tdata;
    end
  end

  // Fetch the word for the round after the current one
  assign rnd_ahead = rnd_r + 6'd1;
  assign rnd_sel   = (state_r == StLoad) ? 6'd0 : rnd_ahead;

  md5bc_round u_round (
    .rnd (rnd_r),
    .km  (km_r),
    .cur (work_r),
    .nxt (round_out)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    wcnt_nxt  = wcnt_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    final_nxt = final_r;
    work_nxt  = work_r;
    for (int k = 0; k < 4; k++) begin
      chain_nxt[k] = chain_r[k];
    end
    case (state_r)
      StIdle: begin
        if (in_acc) begin
          if (in_tuser[0]) begin
            chain_nxt[0] = InitA;
            chain_nxt[1] = InitB;
            chain_nxt[2] = InitC;
            chain_nxt[3] = InitD;
          end
          if (wr_idx == 4'd15) begin
            wcnt_nxt  = 4'd0;
            final_nxt = in_tuser[1];
            state_nxt = StLoad;
          end else begin
            wcnt_nxt = wr_idx + 4'd1;
          end
        end
      end
      StLoad: begin
        work_nxt.a = chain_r[0];
        work_nxt.b = chain_r[1];
        work_nxt.c = chain_r[2];
        work_nxt.d = chain_r[3];
        rnd_nxt    = 6'd0;
        state_nxt  = StRound;
      end
      StRound: begin
        work_nxt = round_out;
        rnd_nxt  = rnd_ahead;
        if (rnd_r == 6'd63) begin
          state_nxt = StAdd;
        end
      end
      StAdd: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        oidx_nxt     = 2'd0;
        state_nxt    = final_r ? StEmit : StIdle;
      end
      StEmit: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            // Drop the chaining state once the digest has gone
            for (int k = 0; k < 4; k++) begin
              chain_nxt[k] = '0;
            end
            state_nxt = StIdle;
          end
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  // Control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= StIdle;
      wcnt_r     <= 4'd0;
      rnd_r      <= 6'd0;
      oidx_r     <= 2'd0;
      final_r    <= 1'b0;
      chain_r[0] <= InitA;
      chain_r[1] <= InitB;
      chain_r[2] <= InitC;
      chain_r[3] <= InitD;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      final_r <= final_nxt;
      for (int k = 0; k < 4; k++) begin
        chain_r[k] <= chain_nxt[k];
      end
    end
  end

  // Working datapath registers; read the next round's word from the store
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    km_r   <= RoundK[rnd_sel] + store[msg_index(rnd_sel)];
  end

endmodule

### sim/testbench.sv
// Self-checking bench for md5_block_compression_top: streams padded message
// words in, predicts every digest item and compares it with what comes out.
// Depends only on md5bc_pkg (for the compiled design) and the top level.
module testbench;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;
  localparam int RandWords  = 165;
  localparam int DirRows    = 25;

  // One expected output item
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        is_last;
  } digest_item_t;

  // One row of the directed stimulus; known marks a typed-in digest
  typedef struct packed {
    logic [31:0] word;
    logic        st;
    logic        fin;
    logic        known;
  } dir_row_t;

  localparam logic [31:0] Md5K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam int Md5Rot [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam logic [31:0] Md5Init [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };

  // Digest of the empty message, little-endian words A..D
  localparam logic [31:0] EmptyDigest [4] = '{
    32'hD98C1DD4, 32'h04B2008F, 32'h980980E9, 32'h7E42F8EC
  };

  // Empty message with mid-block final flags, then restarts mid-block
  localparam dir_row_t DirTab [DirRows] = '{
    '{32'h00000080, 1'b1, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b1},
    '{32'hFFFFFFFF, 1'b1, 1'b1, 1'b0},
    '{32'hFFFFFFFF, 1'b0, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b1, 1'b0},
    '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0},
    '{32'hAAAAAAAA, 1'b1, 1'b0, 1'b0},
    '{32'h55555555, 1'b0, 1'b0, 1'b0},
    '{32'hFFFFFFFF, 1'b1, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b0, 1'b0},
    '{32'h80000001, 1'b0, 1'b1, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] msg_word
  logic [1:0]  in_tuser;   // [0] start_message, [1] final_block
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] digest_word
  logic [1:0]  out_tuser;  // [1:0] digest_index
  logic        out_tlast;

  // Predictor state
  logic [31:0]  chain_word [4];
  logic [31:0]  block_word [16];
  logic [3:0]   word_pos;
  digest_item_t pending_digest [$];

  int words_sent;
  int digests_due;
  int results_seen;
  int mismatches;
  int cycles;
  bit hold_done;

  md5_block_compression_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Run the 64 rounds over the stored block and fold into the chain
  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int g, ph;
    a = chain_word[0];
    b = chain_word[1];
    c = chain_word[2];
    d = chain_word[3];
    for (int i = 0; i < 64; i++) begin
      ph = i / 16;
      case (ph)
        0: begin
          f = d ^ (b & (c ^ d));
          g = i;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotl32(a + f + Md5K[i] + block_word[g], Md5Rot[ph * 4 + i % 4]);
      a = t;
    end
    chain_word[0] += a;
    chain_word[1] += b;
    chain_word[2] += c;
    chain_word[3] += d;
  endtask

  // Absorb one accepted word; queue four digest items after a final block
  task automatic md5_absorb_word(input logic [31:0] w, input logic st, input logic fin,
                                 input logic known);
    digest_item_t item;
    if (st) begin
      chain_word = Md5Init;
      word_pos = 4'd0;
    end
    block_word[word_pos] = w;
    if (word_pos != 4'd15) begin
      word_pos = word_pos + 4'd1;
    end else begin
      word_pos = 4'd0;
      md5_compress();
      if (fin) begin
        for (int k = 0; k < 4; k++) begin
          item.word    = known ? EmptyDigest[k] : chain_word[k];
          item.idx     = 2'(k);
          item.is_last = (k == 3);
          pending_digest.push_back(item);
        end
        digests_due++;
        for (int k = 0; k < 4; k++) chain_word[k] = 32'h0;
      end
    end
  endtask

  // Offer one word after an idle gap and hold it until taken
  task automatic offer_word(input logic [31:0] w, input logic st, input logic fin,
                            input logic known, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= {fin, st};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    md5_absorb_word(w, st, fin, known);
  endtask

  // Mostly random words, with the all-zero and all-one extremes mixed in
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h00000000;
    if (r == 1) return 32'hFFFFFFFF;
    return $urandom;
  endfunction

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("** md5_block_compression_top: FAILED **");
    $finish;
  end

  // Digest sink: random back-pressure, one long hold-off, field checks
  initial begin : digest_sink
    int stall;
    int held;
    digest_item_t want;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= 4) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        held = 0;
        while (held < HoldCycles) begin
          @(posedge clk);
          held++;
        end
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
      if (pending_digest.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest item: word %h index %0d last %0b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want = pending_digest.pop_front();
        if (out_tdata !== want.word || out_tuser !== want.idx ||
            out_tlast !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: want %h/%0d/%0b got %h/%0d/%0b",
                     want.word, want.idx, want.is_last,
                     out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  // Stimulus: reset, directed table, random messages, drain
  initial begin : stimulus
    int gap;
    int nblk;
    int len;
    int msg_count;
    bit burst;
    logic st;
    logic fin;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 32'h0;
    in_tuser   <= 2'b00;
    words_sent   = 0;
    digests_due  = 0;
    results_seen = 0;
    mismatches   = 0;
    hold_done    = 1'b0;
    msg_count    = 0;
    chain_word = Md5Init;
    for (int k = 0; k < 16; k++) block_word[k] = 32'h0;
    word_pos = 4'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < DirRows; i++) begin
      gap = (i < 16) ? 0 : $urandom_range(0, 12);
      offer_word(DirTab[i].word, DirTab[i].st, DirTab[i].fin, DirTab[i].known, gap);
    end

    // Random messages: mostly well-formed, some truncated or restarted
    while (words_sent < DirRows + RandWords) begin
      burst = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 80) begin
        len  = $urandom_range(0, 9);
        nblk = (len < 7) ? 1 : ((len < 9) ? 2 : 3);
        for (int b = 0; b < nblk; b++) begin
          for (int j = 0; j < 16; j++) begin
            st  = (b == 0 && j == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
            fin = (j == 15) ? (b == nblk - 1) : 1'($urandom_range(0, 1));
            gap = burst ? 0 : $urandom_range(0, 12);
            offer_word(pick_word(), st, fin, 1'b0, gap);
          end
        end
      end else begin
        len = $urandom_range(1, 15);
        for (int j = 0; j < len; j++) begin
          st  = (j == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
          fin = 1'($urandom_range(0, 1));
          gap = burst ? 0 : $urandom_range(0, 12);
          offer_word(pick_word(), st, fin, 1'b0, gap);
        end
      end
      msg_count++;
      // Pause once until the block has drained every digest
      if (msg_count == 4) begin
        in_tvalid <= 1'b0;
        while (pending_digest.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then allow a full pass for stray items
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (pending_digest.size() != 0) begin
      mismatches += pending_digest.size();
      $display("%0d digest items never arrived", pending_digest.size());
    end

    $display("Sent %0d message words (%0d directed, %0d messages random),",
             words_sent, DirRows, msg_count);
    $display("checked %0d digest items from %0d digests, %0d mismatches.",
             results_seen, digests_due, mismatches);
    if (mismatches == 0) begin
      $display("** md5_block_compression_top: PASSED **");
    end else begin
      $display("** md5_block_compression_top: FAILED **");
    end
    $finish;
  end

endmodule
